### rtl/ntriples_byte_tokenizer_core_assert.svh
// Assertion macros shared by the tokenizer RTL.
// Each macro checks one implication at the rising clock edge, outside reset.
`ifndef NTRIPLES_BYTE_TOKENIZER_CORE_ASSERT_SVH
`define NTRIPLES_BYTE_TOKENIZER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NBT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/nbt_pkg.sv
// Shared types for the N-Triples byte tokenizer.
// Used by nbt_step, nbt_out_stage and ntriples_byte_tokenizer_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nbt_pkg;

    typedef enum logic [4:0] {
        ST_EXP_SUBJ   = 5'd0,
        ST_EXP_PRED   = 5'd1,
        ST_EXP_OBJ    = 5'd2,
        ST_EXP_DOT    = 5'd3,
        ST_SUBJ_FIRST = 5'd4,
        ST_SUBJ_REST  = 5'd5,
        ST_PRED_FIRST = 5'd6,
        ST_PRED_REST  = 5'd7,
        ST_OBJ_FIRST  = 5'd8,
        ST_OBJ_REST   = 5'd9,
        ST_LIT_FIRST  = 5'd10,
        ST_LIT_REST   = 5'd11,
        ST_AFTER_LIT  = 5'd12,
        ST_LANG_FIRST = 5'd13,
        ST_LANG_REST  = 5'd14,
        ST_CARET      = 5'd15,
        ST_EXP_DT     = 5'd16,
        ST_DT_FIRST   = 5'd17,
        ST_DT_REST    = 5'd18,
        ST_BN_COLON   = 5'd19,
        ST_BN_FIRST   = 5'd20,
        ST_BN_REST    = 5'd21
    } t_state;

    // Role codes carried in the role field of a result word.
    localparam logic [2:0] ROLE_NONE  = 3'd0;
    localparam logic [2:0] ROLE_SUBJ  = 3'd1;
    localparam logic [2:0] ROLE_PRED  = 3'd2;
    localparam logic [2:0] ROLE_OBJ   = 3'd3;
    localparam logic [2:0] ROLE_LIT   = 3'd4;
    localparam logic [2:0] ROLE_LANG  = 3'd5;
    localparam logic [2:0] ROLE_DT    = 3'd6;
    localparam logic [2:0] ROLE_BLANK = 3'd7;

    // Field order matches the output word, first field in the highest bit.
    typedef struct packed {
        logic       error;
        logic       triple_complete;
        logic       triple_done;
        logic       term_end;
        logic       term_start;
        logic [2:0] role;
    } t_result;

    typedef struct packed {
        t_state     state;
        logic [2:0] flags;
        t_result    res;
    } t_step;

endpackage

`default_nettype wire

### rtl/ntriples_byte_tokenizer_core.sv
// N-Triples byte tokenizer: usage
// The slave stream takes one document byte per word in s_axis_tdata, with
// s_axis_tlast high on the final byte of a document. Each accepted byte
// yields exactly one result word on the master stream, in input order.
// Latency: the result of a byte is presented on m_axis_tvalid in the cycle
// after the byte is accepted. Throughput: one byte per cycle while the
// receiver takes results; the parse-state update between the state
// register and the output register is combinational.
// Reset (synchronous, active low) returns the parser to expecting a subject,
// clears the term-presence flags and empties the output register.
// When the receiver stalls, the result word holds on the master side and
// s_axis_tready drops once the output register is full and not being
// taken; the parse state advances only on accepted bytes.
// Depends on nbt_pkg, nbt_step, nbt_out_stage and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "ntriples_byte_tokenizer_core_assert.svh"

module ntriples_byte_tokenizer_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // [7:0] byte_in
    input  wire logic       s_axis_tlast,  // last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    // [2:0] role, [3] term_start, [4] term_end, [5] triple_done,
    // [6] triple_complete, [7] error
    output logic [7:0]      m_axis_tdata
);
    import nbt_pkg::*;

    t_state     r_state;
    logic [2:0] r_flags;
    t_step      step_next;
    t_result    out_data;
    logic       can_load;
    logic       accept;

    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    nbt_step u_step (
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_state (r_state),
        .i_flags (r_flags),
        .o_next  (step_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EXP_SUBJ;
            r_flags <= 3'b000;
        end else if (accept) begin
            r_state <= step_next.state;
            r_flags <= step_next.flags;
        end
    end

    nbt_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_data     (step_next.res),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_data     (out_data),
        .o_can_load (can_load)
    );

    assign m_axis_tdata = {out_data.error, out_data.triple_complete, out_data.triple_done,
                           out_data.term_end, out_data.term_start, out_data.role};

    `NBT_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, accept && s_axis_tlast,
        (r_state == ST_EXP_SUBJ) && (r_flags == 3'b000),
        "final byte did not restart the parser")
    `NBT_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, accept, m_axis_tvalid,
        "accepted byte produced no result")
    `NBT_ASSERT_SAME(a_subj_no_flags, i_clk, i_rst_n, r_state == ST_EXP_SUBJ,
        r_flags == 3'b000, "term flags set while expecting a subject")
    `NBT_ASSERT_SAME(a_complete_needs_done, i_clk, i_rst_n,
        m_axis_tvalid && out_data.triple_complete, out_data.triple_done,
        "complete flag without triple end")
    `NBT_ASSERT_SAME(a_error_is_syntax, i_clk, i_rst_n, m_axis_tvalid && out_data.error,
        (out_data.role == ROLE_NONE) && !out_data.term_start,
        "error byte tagged as term content")

endmodule

`default_nettype wire

### rtl/nbt_step.sv
// Combinational parser step: one byte against the current parse state.
// Depends on nbt_pkg for the state and result types.
`timescale 1ns / 1ps
`default_nettype none

module nbt_step (
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    input  wire nbt_pkg::t_state i_state,
    input  wire logic [2:0]      i_flags,
    output nbt_pkg::t_step       o_next
);
    import nbt_pkg::*;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [1:0] SLOT_SUBJ  = 2'd0;
    localparam logic [1:0] SLOT_PRED  = 2'd1;
    localparam logic [1:0] SLOT_OBJ   = 2'd2;
    localparam logic [1:0] SLOT_AFTER = 2'd3;

    function automatic logic f_is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic t_step f_end_triple(input t_step s);
        t_step t;
        t = s;
        t.res.triple_done     = 1'b1;
        t.res.triple_complete = (s.flags == 3'b111);
        t.flags               = 3'b000;
        t.state               = ST_EXP_SUBJ;
        return t;
    endfunction

    function automatic t_step f_fail(input t_step s);
        t_step t;
        t = s;
        t.res.error = 1'b1;
        if (t.flags != 3'b000) begin
            t = f_end_triple(t);
        end
        t.state = ST_EXP_SUBJ;
        t.flags = 3'b000;
        return t;
    endfunction

    // After the object, a byte that is not whitespace or a dot ends the triple and is read as a subject.
    function automatic t_step f_expect(input logic [1:0] slot, input logic [7:0] c,
                                       input t_step s);
        t_step      t;
        logic [1:0] sl;
        t  = s;
        sl = slot;
        if (f_is_space(c)) begin
            case (sl)
                SLOT_SUBJ: t.state = ST_EXP_SUBJ;
                SLOT_PRED: t.state = ST_EXP_PRED;
                SLOT_OBJ:  t.state = ST_EXP_OBJ;
                default:   t.state = ST_EXP_DOT;
            endcase
        end else if (sl == SLOT_AFTER && c == CH_DOT) begin
            t = f_end_triple(t);
        end else begin
            if (sl == SLOT_AFTER) begin
                t  = f_end_triple(t);
                sl = SLOT_SUBJ;
            end
            if (c == CH_DOT) begin
                t = f_end_triple(t);
            end else if (c == CH_LT) begin
                case (sl)
                    SLOT_SUBJ: begin
                        t.state = ST_SUBJ_FIRST;
                        t.flags = t.flags | 3'b001;
                    end
                    SLOT_PRED: begin
                        t.state = ST_PRED_FIRST;
                        t.flags = t.flags | 3'b010;
                    end
                    default: begin
                        t.state = ST_OBJ_FIRST;
                        t.flags = t.flags | 3'b100;
                    end
                endcase
            end else if (c == CH_QUOTE) begin
                t.state = ST_LIT_FIRST;
                t.flags = t.flags | 3'b100;
            end else if (c == CH_UNDER) begin
                t.state = ST_BN_COLON;
                t.flags = t.flags | 3'b100;
            end else begin
                t = f_fail(t);
            end
        end
        return t;
    endfunction

    function automatic t_step f_closed(input logic [7:0] c, input logic [7:0] closer,
                                       input logic [2:0] role, input logic first,
                                       input t_state rest, input t_state after,
                                       input t_step s);
        t_step t;
        t = s;
        if (c == closer) begin
            t.res.term_end = 1'b1;
            t.state        = after;
        end else begin
            t.res.role       = role;
            t.res.term_start = first;
            t.state          = rest;
        end
        return t;
    endfunction

    function automatic t_step f_open(input logic [7:0] c, input logic [2:0] role,
                                     input logic first, input t_state rest,
                                     input t_step s);
        t_step t;
        t = s;
        if (f_is_space(c)) begin
            t.res.term_end = 1'b1;
            t.state        = ST_EXP_DOT;
        end else if (c == CH_DOT) begin
            t.res.term_end = 1'b1;
            t              = f_end_triple(t);
        end else begin
            t.res.role       = role;
            t.res.term_start = first;
            t.state          = rest;
        end
        return t;
    endfunction

    function automatic logic f_term_open(input t_state st);
        logic open_term;
        case (st)
            ST_SUBJ_FIRST, ST_SUBJ_REST, ST_PRED_FIRST, ST_PRED_REST,
            ST_OBJ_FIRST, ST_OBJ_REST, ST_LIT_FIRST, ST_LIT_REST,
            ST_LANG_FIRST, ST_LANG_REST, ST_DT_FIRST, ST_DT_REST,
            ST_BN_FIRST, ST_BN_REST: open_term = 1'b1;
            default:                 open_term = 1'b0;
        endcase
        return open_term;
    endfunction

    t_step s_cur;
    t_step s_nxt;

    always_comb begin
        s_cur.state = i_state;
        s_cur.flags = i_flags;
        s_cur.res   = '0;
        s_nxt       = s_cur;

        case (i_state)
            ST_EXP_SUBJ:  s_nxt = f_expect(SLOT_SUBJ, i_byte, s_cur);
            ST_EXP_PRED:  s_nxt = f_expect(SLOT_PRED, i_byte, s_cur);
            ST_EXP_OBJ:   s_nxt = f_expect(SLOT_OBJ, i_byte, s_cur);
            ST_EXP_DOT:   s_nxt = f_expect(SLOT_AFTER, i_byte, s_cur);
            ST_SUBJ_FIRST, ST_SUBJ_REST:
                s_nxt = f_closed(i_byte, CH_GT, ROLE_SUBJ, i_state == ST_SUBJ_FIRST,
                                 ST_SUBJ_REST, ST_EXP_PRED, s_cur);
            ST_PRED_FIRST, ST_PRED_REST:
                s_nxt = f_closed(i_byte, CH_GT, ROLE_PRED, i_state == ST_PRED_FIRST,
                                 ST_PRED_REST, ST_EXP_OBJ, s_cur);
            ST_OBJ_FIRST, ST_OBJ_REST:
                s_nxt = f_closed(i_byte, CH_GT, ROLE_OBJ, i_state == ST_OBJ_FIRST,
                                 ST_OBJ_REST, ST_EXP_DOT, s_cur);
            ST_LIT_FIRST, ST_LIT_REST:
                s_nxt = f_closed(i_byte, CH_QUOTE, ROLE_LIT, i_state == ST_LIT_FIRST,
                                 ST_LIT_REST, ST_AFTER_LIT, s_cur);
            ST_AFTER_LIT: begin
                if (i_byte == CH_AT) begin
                    s_nxt.state = ST_LANG_FIRST;
                end else if (i_byte == CH_CARET) begin
                    s_nxt.state = ST_CARET;
                end else begin
                    s_nxt = f_expect(SLOT_AFTER, i_byte, s_cur);
                end
            end
            ST_LANG_FIRST, ST_LANG_REST:
                s_nxt = f_open(i_byte, ROLE_LANG, i_state == ST_LANG_FIRST,
                               ST_LANG_REST, s_cur);
            ST_CARET: begin
                if (i_byte == CH_CARET) begin
                    s_nxt.state = ST_EXP_DT;
                end else begin
                    s_nxt = f_fail(s_cur);
                end
            end
            ST_EXP_DT: begin
                if (i_byte == CH_LT) begin
                    s_nxt.state = ST_DT_FIRST;
                end else begin
                    s_nxt = f_expect(SLOT_AFTER, i_byte, s_cur);
                end
            end
            ST_DT_FIRST, ST_DT_REST:
                s_nxt = f_closed(i_byte, CH_GT, ROLE_DT, i_state == ST_DT_FIRST,
                                 ST_DT_REST, ST_EXP_DOT, s_cur);
            ST_BN_COLON: begin
                if (i_byte == CH_COLON) begin
                    s_nxt.state = ST_BN_FIRST;
                end else begin
                    s_nxt = f_fail(s_cur);
                end
            end
            ST_BN_FIRST, ST_BN_REST:
                s_nxt = f_open(i_byte, ROLE_BLANK, i_state == ST_BN_FIRST,
                               ST_BN_REST, s_cur);
            default: begin
                s_cur.state = ST_EXP_SUBJ;
                s_cur.flags = 3'b000;
                s_nxt       = f_expect(SLOT_SUBJ, i_byte, s_cur);
            end
        endcase

        // The final byte closes whatever is still open unless it already ended a triple, then parsing restarts.
        if (i_last) begin
            if (!s_nxt.res.triple_done) begin
                if (f_term_open(s_nxt.state)) begin
                    s_nxt.res.term_end = 1'b1;
                end
                if (s_nxt.flags != 3'b000) begin
                    s_nxt = f_end_triple(s_nxt);
                end
            end
            s_nxt.state = ST_EXP_SUBJ;
            s_nxt.flags = 3'b000;
        end

        s_nxt.res.triple_complete = s_nxt.res.triple_complete & s_nxt.res.triple_done;
    end

    assign o_next = s_nxt;

endmodule

`default_nettype wire

### rtl/nbt_out_stage.sv
// Output register stage for tokenizer results with a valid/ready handshake.
// Depends on nbt_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module nbt_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire nbt_pkg::t_result i_data,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output nbt_pkg::t_result      o_data,
    output logic                  o_can_load
);
    import nbt_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_data;

    // The stage can take a new word when empty or when its word leaves now.
    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### dv/token_checker.sv
// Scoreboard for the N-Triples byte tokenizer: predicts one result word per accepted byte
// and compares it field by field with the word the block hands out.
// Depends on nbt_pkg for the parse state and result word types.
`timescale 1ns / 1ps

module token_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    input  wire logic       s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // [7:0] byte_in
    input  wire logic       s_axis_tlast,  // last
    input  wire logic       m_axis_tvalid,
    input  wire logic       m_axis_tready,
    // [2:0] role, [3] term_start, [4] term_end, [5] triple_done,
    // [6] triple_complete, [7] error
    input  wire logic [7:0] m_axis_tdata,
    output int              o_mismatches,
    output int              o_pending
);
    import nbt_pkg::*;

    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_QUOTE = "\"";
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_AT    = "@";
    localparam logic [7:0] CH_CARET = "^";
    localparam logic [7:0] CH_DOT   = ".";

    localparam int SEEN_SUBJ = 0;
    localparam int SEEN_PRED = 1;
    localparam int SEEN_OBJ  = 2;

    t_state     parser_state = ST_EXP_SUBJ;
    logic [2:0] terms_seen   = 3'b000;
    t_result    expected_words[$];
    int         mismatches   = 0;

    assign o_mismatches = mismatches;

    function automatic logic is_ws(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic term_open(t_state st);
        return (st >= ST_SUBJ_FIRST && st <= ST_LIT_REST) ||
               st inside {ST_LANG_FIRST, ST_LANG_REST, ST_DT_FIRST, ST_DT_REST,
                          ST_BN_FIRST, ST_BN_REST};
    endfunction

    task automatic end_triple(inout t_result r);
        r.triple_done     = 1'b1;
        r.triple_complete = (terms_seen == 3'b111);
        terms_seen        = 3'b000;
        parser_state      = ST_EXP_SUBJ;
    endtask

    task automatic reject_byte(inout t_result r);
        r.error = 1'b1;
        if (terms_seen != 3'b000) end_triple(r);
        parser_state = ST_EXP_SUBJ;
        terms_seen   = 3'b000;
    endtask

    // Between terms: whitespace keeps the slot; '<' opens its term, quote/'_' an object.
    task automatic expect_term(input t_state slot, input logic [7:0] c, inout t_result r);
        t_state s;
        s = slot;
        if (is_ws(c)) begin
            parser_state = slot;
        end else if (c == CH_DOT) begin
            end_triple(r);
        end else begin
            // A term that begins after the object closes the triple first.
            if (s == ST_EXP_DOT) begin
                end_triple(r);
                s = ST_EXP_SUBJ;
            end
            if (c == CH_LT) begin
                case (s)
                    ST_EXP_SUBJ: begin
                        parser_state = ST_SUBJ_FIRST;
                        terms_seen[SEEN_SUBJ] = 1'b1;
                    end
                    ST_EXP_PRED: begin
                        parser_state = ST_PRED_FIRST;
                        terms_seen[SEEN_PRED] = 1'b1;
                    end
                    default: begin
                        parser_state = ST_OBJ_FIRST;
                        terms_seen[SEEN_OBJ] = 1'b1;
                    end
                endcase
            end else if (c == CH_QUOTE) begin
                parser_state = ST_LIT_FIRST;
                terms_seen[SEEN_OBJ] = 1'b1;
            end else if (c == CH_UNDER) begin
                parser_state = ST_BN_COLON;
                terms_seen[SEEN_OBJ] = 1'b1;
            end else begin
                reject_byte(r);
            end
        end
    endtask

    task automatic closed_content(input logic [7:0] c, input logic [7:0] closer,
                                  input logic [2:0] role, input logic first,
                                  input t_state rest, input t_state after,
                                  inout t_result r);
        if (c == closer) begin
            r.term_end   = 1'b1;
            parser_state = after;
        end else begin
            r.role       = role;
            r.term_start = first;
            parser_state = rest;
        end
    endtask

    task automatic open_content(input logic [7:0] c, input logic [2:0] role,
                                input logic first, input t_state rest, inout t_result r);
        if (is_ws(c)) begin
            r.term_end   = 1'b1;
            parser_state = ST_EXP_DOT;
        end else if (c == CH_DOT) begin
            r.term_end = 1'b1;
            end_triple(r);
        end else begin
            r.role       = role;
            r.term_start = first;
            parser_state = rest;
        end
    endtask

    task automatic tokenize_byte(input logic [7:0] c, input logic fin, output t_result r);
        t_state st;
        r  = '0;
        st = parser_state;
        case (st)
            ST_EXP_SUBJ, ST_EXP_PRED, ST_EXP_OBJ, ST_EXP_DOT:
                expect_term(st, c, r);
            ST_SUBJ_FIRST, ST_SUBJ_REST:
                closed_content(c, CH_GT, ROLE_SUBJ, st == ST_SUBJ_FIRST, ST_SUBJ_REST,
                               ST_EXP_PRED, r);
            ST_PRED_FIRST, ST_PRED_REST:
                closed_content(c, CH_GT, ROLE_PRED, st == ST_PRED_FIRST, ST_PRED_REST,
                               ST_EXP_OBJ, r);
            ST_OBJ_FIRST, ST_OBJ_REST:
                closed_content(c, CH_GT, ROLE_OBJ, st == ST_OBJ_FIRST, ST_OBJ_REST,
                               ST_EXP_DOT, r);
            ST_LIT_FIRST, ST_LIT_REST:
                closed_content(c, CH_QUOTE, ROLE_LIT, st == ST_LIT_FIRST, ST_LIT_REST,
                               ST_AFTER_LIT, r);
            ST_AFTER_LIT: begin
                if (c == CH_AT) parser_state = ST_LANG_FIRST;
                else if (c == CH_CARET) parser_state = ST_CARET;
                else expect_term(ST_EXP_DOT, c, r);
            end
            ST_LANG_FIRST, ST_LANG_REST:
                open_content(c, ROLE_LANG, st == ST_LANG_FIRST, ST_LANG_REST, r);
            ST_CARET: begin
                if (c == CH_CARET) parser_state = ST_EXP_DT;
                else reject_byte(r);
            end
            ST_EXP_DT: begin
                if (c == CH_LT) parser_state = ST_DT_FIRST;
                else expect_term(ST_EXP_DOT, c, r);
            end
            ST_DT_FIRST, ST_DT_REST:
                closed_content(c, CH_GT, ROLE_DT, st == ST_DT_FIRST, ST_DT_REST,
                               ST_EXP_DOT, r);
            ST_BN_COLON: begin
                if (c == CH_COLON) parser_state = ST_BN_FIRST;
                else reject_byte(r);
            end
            ST_BN_FIRST, ST_BN_REST:
                open_content(c, ROLE_BLANK, st == ST_BN_FIRST, ST_BN_REST, r);
            default: begin
                parser_state = ST_EXP_SUBJ;
                terms_seen   = 3'b000;
                expect_term(ST_EXP_SUBJ, c, r);
            end
        endcase

        // The final byte closes whatever is still open unless it already ended a triple.
        if (fin) begin
            if (!r.triple_done) begin
                if (term_open(parser_state)) r.term_end = 1'b1;
                if (terms_seen != 3'b000) end_triple(r);
            end
            parser_state = ST_EXP_SUBJ;
            terms_seen   = 3'b000;
        end
    endtask

    task automatic check_field(input string name, input logic [2:0] want,
                               input logic [2:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            expected_words.delete();
            parser_state = ST_EXP_SUBJ;
            terms_seen   = 3'b000;
        end else begin
            // The result word leaving now belongs to an earlier byte, so pop first.
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata);
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result word %h arrived with no byte pending",
                             $time, m_axis_tdata);
                end else begin
                    want = expected_words.pop_front();
                    check_field("role", want.role, got.role);
                    check_field("term_start", 3'(want.term_start), 3'(got.term_start));
                    check_field("term_end", 3'(want.term_end), 3'(got.term_end));
                    check_field("triple_done", 3'(want.triple_done), 3'(got.triple_done));
                    check_field("triple_complete", 3'(want.triple_complete),
                                3'(got.triple_complete));
                    check_field("error", 3'(want.error), 3'(got.error));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                tokenize_byte(s_axis_tdata, s_axis_tlast, want);
                expected_words.push_back(want);
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

### dv/testbench.sv
// Top of the tokenizer testbench: clock, reset, byte stimulus and receiver backpressure.
// Instantiates ntriples_byte_tokenizer_core and token_checker, which compares the result words.
`timescale 1ns / 1ps

module testbench;

    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_QUOTE = "\"";
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_AT    = "@";
    localparam logic [7:0] CH_CARET = "^";
    localparam logic [7:0] CH_DOT   = ".";

    localparam int TARGET_BYTES = 750;
    localparam int QUIET_LIMIT  = 1000;
    localparam int END_CYCLES   = 20;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tready = 1'b0;
    wire        s_axis_tready;
    wire        m_axis_tvalid;
    wire  [7:0] m_axis_tdata;

    int         mismatches;
    int         pending;
    int         sent_count  = 0;
    int         quiet_count = 0;
    bit         tx_calm     = 1'b0;
    bit         rx_calm     = 1'b0;
    logic [7:0] doc[$];

    ntriples_byte_tokenizer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    token_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Ends a hung run: counts cycles in which neither side moves a word.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic logic [7:0] pick_other(logic [7:0] excl);
        logic [7:0] c;
        c = excl;
        while (c == excl) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Content of a blank label or language tag: anything but whitespace and '.'.
    function automatic logic [7:0] pick_open_byte();
        logic [7:0] c;
        c = CH_DOT;
        while (c == CH_DOT || c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] pick_junk();
        case ($urandom_range(0, 17))
            0: return CH_LT;
            1: return CH_GT;
            2: return CH_QUOTE;
            3: return CH_UNDER;
            4: return CH_COLON;
            5: return CH_AT;
            6: return CH_CARET;
            7: return CH_DOT;
            8: return pick_ws();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) doc.push_back(s[k]);
    endtask

    task automatic add_space();
        repeat ($urandom_range(0, 2)) doc.push_back(pick_ws());
    endtask

    task automatic add_noise();
        if ($urandom_range(0, 11) == 0) doc.push_back(pick_junk());
    endtask

    task automatic add_closed(input logic [7:0] opener, input logic [7:0] closer);
        doc.push_back(opener);
        repeat ($urandom_range(0, 6)) doc.push_back(pick_other(closer));
        doc.push_back(closer);
    endtask

    task automatic add_label();
        doc.push_back(CH_UNDER);
        doc.push_back(($urandom_range(0, 7) == 0) ? pick_other(CH_COLON) : CH_COLON);
        repeat ($urandom_range(1, 4)) doc.push_back(pick_open_byte());
        doc.push_back(pick_ws());
    endtask

    task automatic add_triple();
        add_space();
        add_noise();
        if ($urandom_range(0, 4) == 0) add_label();
        else add_closed(CH_LT, CH_GT);
        add_space();
        add_noise();
        add_closed(CH_LT, CH_GT);
        add_space();
        add_noise();
        case ($urandom_range(0, 4))
            0: add_closed(CH_LT, CH_GT);
            1: add_label();
            2: add_closed(CH_QUOTE, CH_QUOTE);
            3: begin
                add_closed(CH_QUOTE, CH_QUOTE);
                doc.push_back(CH_AT);
                repeat ($urandom_range(0, 3)) doc.push_back(pick_open_byte());
                doc.push_back(pick_ws());
            end
            default: begin
                add_closed(CH_QUOTE, CH_QUOTE);
                doc.push_back(CH_CARET);
                doc.push_back(($urandom_range(0, 5) == 0) ? pick_other(CH_CARET) : CH_CARET);
                add_closed(CH_LT, CH_GT);
            end
        endcase
        add_space();
        if ($urandom_range(0, 3) != 0) doc.push_back(CH_DOT);
        add_space();
    endtask

    task automatic send_byte(input logic [7:0] c, input logic fin);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    // Sends the document with tlast on its final byte; a cut one ends mid-stream.
    task automatic send_doc(input bit may_cut);
        int n;
        n = doc.size();
        if (may_cut && n > 1 && $urandom_range(0, 7) == 0) n = $urandom_range(1, n - 1);
        for (int k = 0; k < n; k++) send_byte(doc[k], k == n - 1);
        doc.delete();
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Byte extremes inside IRI and literal, an empty predicate, and a language tag.
        doc.push_back(CH_LT);
        doc.push_back(8'h00);
        doc.push_back(CH_GT);
        add_text("<>\"");
        doc.push_back(8'hFF);
        add_text("\"@e.");
        send_doc(1'b0);
        // A lone dot, a stray byte, then a blank object cut off by a literal with a datatype.
        add_text(".");
        send_doc(1'b0);
        add_text("%");
        send_doc(1'b0);
        add_text("_:b\t\"q\"^^<d>");
        send_doc(1'b0);
        drain_results();

        while (sent_count < TARGET_BYTES) begin
            if ($urandom_range(0, 3) == 0) tx_calm = !tx_calm;
            if ($urandom_range(0, 9) == 0) drain_results();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) doc.push_back(pick_junk());
            end else begin
                repeat ($urandom_range(1, 4)) add_triple();
            end
            send_doc(1'b1);
        end

        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/nbt_pkg.sv
rtl/nbt_step.sv
rtl/nbt_out_stage.sv
rtl/ntriples_byte_tokenizer_core.sv
dv/token_checker.sv
dv/testbench.sv
